### rtl/core/svpwm_pkg.sv
// Shared types and constants for the SVPWM duty calculator.
// No dependencies; used by every module under rtl/core.
package svpwm_pkg;

  // Pipeline depth, input register through output register
  localparam int NUM_STAGES = 8;

  // Fractional bits of the Q30 active-time numerators
  localparam int Q30_BITS = 30;

  // 1/sqrt3 and 2/sqrt3 in unsigned Q2.15, rounded to nearest
  localparam logic signed [31:0] K_INV_SQRT3     = 32'sd18919;
  localparam logic signed [31:0] K_TWO_INV_SQRT3 = 32'sd37837;

  localparam logic [15:0] PERIOD_RESET = 16'd1999;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  typedef enum logic [2:0] {
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5,
    SECTOR_6 = 3'd6
  } sector_t;

endpackage

### rtl/core/svpwm_duty_calculator.sv
// Space vector PWM duty calculator, top level: period register and pipeline control.
// Instantiates svpwm_front, svpwm_time and svpwm_duty; depends on svpwm_pkg.
//
// Takes one alpha-beta reference word per clock while the output is not stalled and
// returns the sector and three centered compare values, saturated to 0..period. The
// datapath is an eight-stage pipeline (constant multiply, numerator sums, sector
// select, period multiply, truncation, lead value, phase offsets, saturation into the
// output register), with a sustained rate of one word per cycle while out_ready stays
// high. Each stage holds its word while the stage after it is full and cannot pass its
// own word on, so back pressure on the output fills bubbles first and then stalls the
// input. The period register (low PERIOD_WIDTH bits kept, at most 16) is always ready
// to be written and must only change while no word is in flight.
module svpwm_duty_calculator #(
  parameter int PERIOD_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        pwm_period,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] alpha_ref,
  input  logic signed [15:0] beta_ref,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        duty_u,
  output logic [15:0]        duty_v,
  output logic [15:0]        duty_w,
  output logic [2:0]         sector_number
);

  localparam int PW = (PERIOD_WIDTH < 16) ? PERIOD_WIDTH : 16;
  localparam int NS = svpwm_pkg::NUM_STAGES;

  logic [PW-1:0]        period;
  logic [NS-1:0]        stage_valid;
  logic [NS:0]          stage_adv;
  svpwm_pkg::stage_en_t stage_en;

  logic                 a_neg, b_neg;
  logic signed [31:0]   amk, apk, kma, nak, k2b, nk2b;
  logic signed [PW+1:0] t1, t2;
  svpwm_pkg::sector_t   sector;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PW'(svpwm_pkg::PERIOD_RESET);
    end else if (cfg_valid && cfg_ready) begin
      period <= pwm_period[PW-1:0];
    end
  end

  // a stage loads when it is empty or its word moves on
  always_comb begin
    stage_adv[NS] = out_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      stage_adv[i] = !stage_valid[i] || stage_adv[i+1];
    end
  end

  assign stage_en  = stage_adv[NS-1:0];
  assign in_ready  = stage_adv[0];
  assign out_valid = stage_valid[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_adv[0]) stage_valid[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (stage_adv[i]) stage_valid[i] <= stage_valid[i-1];
      end
    end
  end

  svpwm_front u_front (
    .clk       (clk),
    .stage_en  (stage_en),
    .alpha_ref (alpha_ref),
    .beta_ref  (beta_ref),
    .a_neg     (a_neg),
    .b_neg     (b_neg),
    .amk       (amk),
    .apk       (apk),
    .kma       (kma),
    .nak       (nak),
    .k2b       (k2b),
    .nk2b      (nk2b)
  );

  svpwm_time #(
    .PERIOD_W (PW)
  ) u_time (
    .clk      (clk),
    .stage_en (stage_en),
    .period   (period),
    .a_neg    (a_neg),
    .b_neg    (b_neg),
    .amk      (amk),
    .apk      (apk),
    .kma      (kma),
    .nak      (nak),
    .k2b      (k2b),
    .nk2b     (nk2b),
    .t1       (t1),
    .t2       (t2),
    .sector   (sector)
  );

  svpwm_duty #(
    .PERIOD_W (PW)
  ) u_duty (
    .clk           (clk),
    .stage_en      (stage_en),
    .period        (period),
    .t1            (t1),
    .t2            (t2),
    .sector        (sector),
    .duty_u        (duty_u),
    .duty_v        (duty_v),
    .duty_w        (duty_w),
    .sector_number (sector_number)
  );

`ifndef SYNTHESIS
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&stage_valid))
    else $error("input stalled with a bubble in the pipeline");

  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sector_number != 3'd0 && sector_number != 3'd7))
    else $error("sector out of range");

  a_duty_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duty_u <= 16'(period) && duty_v <= 16'(period)
                   && duty_w <= 16'(period)))
    else $error("duty above period");

  a_sector1_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sector_number == 3'(svpwm_pkg::SECTOR_1))
      |-> (duty_u >= duty_v && duty_v >= duty_w))
    else $error("sector 1 phase order broken");
`endif

endmodule

### rtl/core/svpwm_front.sv
// Front end: Q30 alpha, beta/sqrt3 products, then the six candidate numerators.
// Pipeline stages 0 and 1. Depends on svpwm_pkg.
module svpwm_front (
  input  logic                    clk,
  input  svpwm_pkg::stage_en_t    stage_en,
  input  logic signed [15:0]      alpha_ref,
  input  logic signed [15:0]      beta_ref,
  output logic                    a_neg,
  output logic                    b_neg,
  output logic signed [31:0]      amk,
  output logic signed [31:0]      apk,
  output logic signed [31:0]      kma,
  output logic signed [31:0]      nak,
  output logic signed [31:0]      k2b,
  output logic signed [31:0]      nk2b
);

  logic signed [31:0] beta_x;
  logic signed [31:0] a0;
  logic signed [31:0] kb0;
  logic signed [31:0] k2b0;

  assign beta_x = 32'(beta_ref);

  // stage 0: alpha to Q30, beta times the Q2.15 constants
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      a0   <= $signed({alpha_ref[15], alpha_ref, 15'b0});
      kb0  <= beta_x * svpwm_pkg::K_INV_SQRT3;
      k2b0 <= beta_x * svpwm_pkg::K_TWO_INV_SQRT3;
    end
  end

  // stage 1: every sum any sector needs, all fit in 32 bits signed
  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      a_neg <= a0[31];
      b_neg <= kb0[31];
      amk   <= a0 - kb0;
      apk   <= a0 + kb0;
      kma   <= kb0 - a0;
      nak   <= -a0 - kb0;
      k2b   <= k2b0;
      nk2b  <= -k2b0;
    end
  end

endmodule

### rtl/core/svpwm_time.sv
// Sector decision, active-time scaling by the period and truncation toward zero.
// Pipeline stages 2 to 4. Depends on svpwm_pkg.
module svpwm_time #(
  parameter int PERIOD_W = 16
) (
  input  logic                    clk,
  input  svpwm_pkg::stage_en_t    stage_en,
  input  logic [PERIOD_W-1:0]     period,
  input  logic                    a_neg,
  input  logic                    b_neg,
  input  logic signed [31:0]      amk,
  input  logic signed [31:0]      apk,
  input  logic signed [31:0]      kma,
  input  logic signed [31:0]      nak,
  input  logic signed [31:0]      k2b,
  input  logic signed [31:0]      nk2b,
  output logic signed [PERIOD_W+1:0] t1,
  output logic signed [PERIOD_W+1:0] t2,
  output svpwm_pkg::sector_t      sector
);

  localparam int TW     = PERIOD_W + 2;
  localparam int PROD_W = PERIOD_W + 33;
  localparam logic signed [PROD_W-1:0] TRUNC_BIAS =
    PROD_W'((64'd1 << svpwm_pkg::Q30_BITS) - 64'd1);

  function automatic logic is_pos(input logic signed [31:0] x);
    return !x[31] && (x != 32'sd0);
  endfunction

  svpwm_pkg::sector_t   sector_c, sector2, sector3;
  logic signed [31:0]   n1_c, n2_c, n1, n2;
  logic signed [PROD_W-1:0] per_x;
  logic signed [PROD_W-1:0] p1, p2;
  logic signed [PROD_W-1:0] p1_b, p2_b;

  // kma > 0 means beta/sqrt3 > alpha, nak > 0 means -beta/sqrt3 > alpha
  always_comb begin
    if (!b_neg) begin
      if (!a_neg) sector_c = is_pos(kma) ? svpwm_pkg::SECTOR_2 : svpwm_pkg::SECTOR_1;
      else        sector_c = is_pos(nak) ? svpwm_pkg::SECTOR_3 : svpwm_pkg::SECTOR_2;
    end else begin
      if (!a_neg) sector_c = is_pos(nak) ? svpwm_pkg::SECTOR_5 : svpwm_pkg::SECTOR_6;
      else        sector_c = is_pos(kma) ? svpwm_pkg::SECTOR_4 : svpwm_pkg::SECTOR_5;
    end
  end

  always_comb begin
    unique case (sector_c)
      svpwm_pkg::SECTOR_1: begin n1_c = amk;  n2_c = k2b;  end
      svpwm_pkg::SECTOR_2: begin n1_c = apk;  n2_c = kma;  end
      svpwm_pkg::SECTOR_3: begin n1_c = k2b;  n2_c = nak;  end
      svpwm_pkg::SECTOR_4: begin n1_c = kma;  n2_c = nk2b; end
      svpwm_pkg::SECTOR_5: begin n1_c = nak;  n2_c = amk;  end
      default:             begin n1_c = nk2b; n2_c = apk;  end
    endcase
  end

  // stage 2: sector and numerator select
  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      sector2 <= sector_c;
      n1      <= n1_c;
      n2      <= n2_c;
    end
  end

  assign per_x = $signed(PROD_W'(period));

  // stage 3: numerator times period
  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      sector3 <= sector2;
      p1      <= PROD_W'(n1) * per_x;
      p2      <= PROD_W'(n2) * per_x;
    end
  end

  // divide by 2^30, truncating toward zero
  assign p1_b = p1 + (p1[PROD_W-1] ? TRUNC_BIAS : '0);
  assign p2_b = p2 + (p2[PROD_W-1] ? TRUNC_BIAS : '0);

  // stage 4
  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      sector <= sector3;
      t1     <= p1_b[svpwm_pkg::Q30_BITS +: TW];
      t2     <= p2_b[svpwm_pkg::Q30_BITS +: TW];
    end
  end

endmodule

### rtl/core/svpwm_duty.sv
// Centered compare values: lead, mid and last phase, phase mapping, saturation.
// Pipeline stages 5 to 7; stage 7 is the output register. Depends on svpwm_pkg.
module svpwm_duty #(
  parameter int PERIOD_W = 16
) (
  input  logic                       clk,
  input  svpwm_pkg::stage_en_t       stage_en,
  input  logic [PERIOD_W-1:0]        period,
  input  logic signed [PERIOD_W+1:0] t1,
  input  logic signed [PERIOD_W+1:0] t2,
  input  svpwm_pkg::sector_t         sector,
  output logic [15:0]                duty_u,
  output logic [15:0]                duty_v,
  output logic [15:0]                duty_w,
  output logic [2:0]                 sector_number
);

  localparam int DW = PERIOD_W + 5;

  function automatic logic [15:0] sat_duty(input logic signed [DW-1:0] v,
                                           input logic [PERIOD_W-1:0] p);
    logic signed [DW-1:0] pe;
    pe = $signed(DW'(p));
    if (v[DW-1])      return 16'd0;
    else if (v > pe)  return 16'(p);
    else              return 16'(v[PERIOD_W-1:0]);
  endfunction

  logic signed [DW-1:0] sum_c, sum_b, lead_c;
  logic signed [DW-1:0] lead5, lead6, mid6, last6;
  logic signed [PERIOD_W+1:0] t1_5, t2_5;
  svpwm_pkg::sector_t   sector5, sector6;
  logic signed [DW-1:0] u_c, v_c, w_c;

  // (period + t1 + t2) / 2, truncated toward zero
  assign sum_c  = $signed(DW'(period)) + DW'(t1) + DW'(t2);
  assign sum_b  = sum_c + $signed({{(DW-1){1'b0}}, sum_c[DW-1]});
  assign lead_c = sum_b >>> 1;

  // stage 5
  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      sector5 <= sector;
      lead5   <= lead_c;
      t1_5    <= t1;
      t2_5    <= t2;
    end
  end

  // stage 6: odd sectors step down by t1 first, even sectors by t2
  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      sector6 <= sector5;
      lead6   <= lead5;
      last6   <= lead5 - DW'(t1_5) - DW'(t2_5);
      case (sector5) inside
        svpwm_pkg::SECTOR_1, svpwm_pkg::SECTOR_3, svpwm_pkg::SECTOR_5:
          mid6 <= lead5 - DW'(t1_5);
        default:
          mid6 <= lead5 - DW'(t2_5);
      endcase
    end
  end

  always_comb begin
    unique case (sector6)
      svpwm_pkg::SECTOR_1: begin u_c = lead6; v_c = mid6;  w_c = last6; end
      svpwm_pkg::SECTOR_2: begin v_c = lead6; u_c = mid6;  w_c = last6; end
      svpwm_pkg::SECTOR_3: begin v_c = lead6; w_c = mid6;  u_c = last6; end
      svpwm_pkg::SECTOR_4: begin w_c = lead6; v_c = mid6;  u_c = last6; end
      svpwm_pkg::SECTOR_5: begin w_c = lead6; u_c = mid6;  v_c = last6; end
      default:             begin u_c = lead6; w_c = mid6;  v_c = last6; end
    endcase
  end

  // stage 7: output register
  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      duty_u        <= sat_duty(u_c, period);
      duty_v        <= sat_duty(v_c, period);
      duty_w        <= sat_duty(w_c, period);
      sector_number <= sector6;
    end
  end

endmodule
